@@ rtl/core/refractory_probability_filter_core_macros.svh @@
// ---------------------------------------------------------------------------
// Refractory probability filter assertion macros
// Shorthand for clocked, reset-qualified implication checks.
// ---------------------------------------------------------------------------
`ifndef REFRACTORY_PROBABILITY_FILTER_CORE_MACROS_SVH
`define REFRACTORY_PROBABILITY_FILTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst is high.
`define RPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and ignored while rst is high.
`define RPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rpf_pkg.sv @@
// ---------------------------------------------------------------------------
// Refractory probability filter package
// Shared widths, constants, register indexes and types.
// ---------------------------------------------------------------------------
package rpf_pkg;

  localparam int unsigned TAPS_DEFAULT = 6;
  localparam int unsigned WEIGHT_REGS  = 6;

  localparam int unsigned PROB_W  = 16;
  localparam int unsigned TIU_W   = 3;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned PROD_W  = 2 * PROB_W;
  // Six products of two 16-bit values fit in 35 bits.
  localparam int unsigned SUM_W   = PROD_W + 3;
  localparam int unsigned DIFF_W  = SUM_W + 1;
  localparam int unsigned X_W     = DIFF_W + PROB_W + 1;
  // Nonnegative x at most one (2^45) plus the rounding half fits in 47 bits.
  localparam int unsigned RND_W   = 47;

  localparam logic [PROB_W-1:0] ONE_Q15 = PROB_W'(32768);
  localparam logic [DIFF_W-1:0] ONE_Q30 = DIFF_W'(64'd1 << 30);
  localparam logic [X_W-1:0]    ONE_X   = X_W'(64'd1 << 45);
  localparam logic [RND_W-1:0]  HALF_X  = RND_W'(64'd1 << 29);
  localparam int unsigned       FRAC_SHIFT = 30;

  typedef enum logic [IDX_W-1:0] {
    REG_TAPS_IN_USE = 3'd0,
    REG_WEIGHT_1    = 3'd1,
    REG_WEIGHT_2    = 3'd2,
    REG_WEIGHT_3    = 3'd3,
    REG_WEIGHT_4    = 3'd4,
    REG_WEIGHT_5    = 3'd5,
    REG_WEIGHT_6    = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ rtl/core/rpf_cell.sv @@
// ---------------------------------------------------------------------------
// Refractory filter cell
// Holds one history entry and adds its weighted term to the passing sum.
// ---------------------------------------------------------------------------
module rpf_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  rpf_pkg::cell_ctrl_t        ctrl,
  input  logic [rpf_pkg::PROB_W-1:0] hist_in,
  input  logic [rpf_pkg::PROB_W-1:0] weight,
  input  logic                       active,
  input  logic [rpf_pkg::SUM_W-1:0]  sum_in,
  output logic [rpf_pkg::PROB_W-1:0] hist,
  output logic [rpf_pkg::SUM_W-1:0]  sum_out
);
  import rpf_pkg::*;

  logic [PROD_W-1:0] term;

  assign term = active ? (weight * hist) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (ctrl.clear) begin
      hist <= '0;
    end else if (ctrl.shift) begin
      hist <= hist_in;
    end
  end

  // The partial sum moves one cell down the chain every cycle.
  always_ff @(posedge clk) begin
    sum_out <= sum_in + SUM_W'(term);
  end

endmodule

@@ rtl/core/refractory_probability_filter_core.sv @@
// ---------------------------------------------------------------------------
// Refractory probability filter core
// Scales each Q1.15 firing probability by one minus a weighted sum of the
// stream's recent outputs, clamps the result to zero..one and keeps it as
// history for the samples that follow.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  ----------------------------------
//  in        sink       in_valid/in_ready   probability, series_start
//  out       source     out_valid/out_ready refractory_probability, saturated
//  cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// The block takes one beat at a time: it accepts no new beat until the last
// one has been pushed. The partial sum crosses one cell per cycle in ST_SUM,
// then ST_MUL registers the final multiply, ST_OUT does rounding, clamping
// and the history push, and ST_IDLE takes the next beat.
// Reset clears the configuration registers and every history entry.
// A result that is not taken holds the output register; a following beat is
// still accepted and runs its sum, and stalls only before its own push.
//
`include "refractory_probability_filter_core_macros.svh"

module refractory_probability_filter_core #(
  parameter int unsigned TAPS = rpf_pkg::TAPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rpf_pkg::PROB_W-1:0] probability,
  input  logic                       series_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rpf_pkg::PROB_W-1:0] refractory_probability,
  output logic                       saturated,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rpf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rpf_pkg::DATA_W-1:0] cfg_data
);
  import rpf_pkg::*;

  localparam int unsigned CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  // Configuration registers. Writes are taken in every cycle.
  logic [TIU_W-1:0]  taps_in_use;
  logic [PROB_W-1:0] weights [WEIGHT_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use <= '0;
      for (int i = 0; i < WEIGHT_REGS; i++) begin
        weights[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_TAPS_IN_USE: taps_in_use <= cfg_data[TIU_W-1:0];
        REG_WEIGHT_1:    weights[0]  <= cfg_data;
        REG_WEIGHT_2:    weights[1]  <= cfg_data;
        REG_WEIGHT_3:    weights[2]  <= cfg_data;
        REG_WEIGHT_4:    weights[3]  <= cfg_data;
        REG_WEIGHT_5:    weights[4]  <= cfg_data;
        REG_WEIGHT_6:    weights[5]  <= cfg_data;
        default: begin
          // Indexes past the register list are dropped.
        end
      endcase
    end
  end

  // Sequencer state.
  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [PROB_W-1:0] prob;
  logic signed [X_W-1:0] x;
  cell_ctrl_t        ctrl;
  logic              push;

  // Cell chain. Entry 0 is the output one sample back; the sum enters at
  // cell 0 as zero and leaves through the register of the last cell.
  logic [PROB_W-1:0] hist     [TAPS];
  logic [SUM_W-1:0]  sum_chain[TAPS+1];
  logic [PROB_W-1:0] result;
  logic              result_sat;

  assign sum_chain[0] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic [PROB_W-1:0] cell_weight;
    logic              cell_active;
    logic [PROB_W-1:0] cell_hist_in;

    // Lags past the weight registers carry no weight.
    if (k < WEIGHT_REGS) begin : g_weighted
      assign cell_weight = weights[k];
      assign cell_active = (TIU_W'(k) < taps_in_use);
    end else begin : g_plain
      assign cell_weight = '0;
      assign cell_active = 1'b0;
    end

    if (k == 0) begin : g_head
      assign cell_hist_in = result;
    end else begin : g_body
      assign cell_hist_in = hist[k-1];
    end

    rpf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .hist_in (cell_hist_in),
      .weight  (cell_weight),
      .active  (cell_active),
      .sum_in  (sum_chain[k]),
      .hist    (hist[k]),
      .sum_out (sum_chain[k+1])
    );
  end

  // Final scaling: x = probability * (one - sum), exact and signed.
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROB_W:0]   prob_s;
  logic signed [X_W-1:0]    x_next;

  assign diff   = $signed(ONE_Q30) - $signed({1'b0, sum_chain[TAPS]});
  assign prob_s = $signed({1'b0, prob});
  assign x_next = prob_s * diff;

  // Round half up to Q1.15 and clamp to zero..one.
  logic [RND_W-1:0] x_rnd;

  assign x_rnd = x[RND_W-1:0] + HALF_X;

  always_comb begin
    if (x[X_W-1]) begin
      result     = '0;
      result_sat = 1'b1;
    end else if (x > $signed(ONE_X)) begin
      result     = ONE_Q15;
      result_sat = 1'b1;
    end else begin
      result     = x_rnd[FRAC_SHIFT +: PROB_W];
      result_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctrl       = '0;
    push       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // A series start wipes the history in the accepting cycle.
          ctrl.clear = series_start;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (count == CNT_W'(TAPS - 1)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          push       = 1'b1;
          ctrl.shift = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      count <= '0;
      prob  <= probability;
    end else if (state == ST_SUM) begin
      count <= count + CNT_W'(1);
    end
    if (state == ST_MUL) begin
      x <= x_next;
    end
  end

  // Output register: the handshake on out is decoupled from the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      refractory_probability <= result;
      saturated              <= result_sat;
    end
  end

  // Shorthands for the checks below.
  logic in_beat;
  logic out_at_bound;

  assign in_beat      = in_valid && in_ready;
  assign out_at_bound = (refractory_probability == '0) || (refractory_probability == ONE_Q15);

  `RPF_ASSERT_IMP(a_out_range, out_valid, refractory_probability <= ONE_Q15, "result above one")
  `RPF_ASSERT_IMP(a_sat_clamp, out_valid && saturated, out_at_bound, "saturated off bound")
  `RPF_ASSERT_NXT(a_one_beat, in_beat, !in_ready, "second beat taken while busy")
  `RPF_ASSERT_NXT(a_start_clear, in_beat && series_start, hist[0] == '0, "history not cleared")

endmodule

@@ test/testbench.sv @@
// ---------------------------------------------------------------------------
// Refractory probability filter core testbench
// Drives Q1.15 probability beats through the filter under random idling on
// both sides, predicts each refractory output from a local copy of the
// configuration and output history, and compares every output beat in order.
// ---------------------------------------------------------------------------
module testbench;
  import rpf_pkg::*;

  localparam int unsigned TAPS = TAPS_DEFAULT;

  // Write index with no register behind it; the block must ignore it.
  localparam logic [IDX_W-1:0] REG_INDEX_UNUSED = 3'd7;

  // Fixed-point anchors for the prediction: one in Q2.30, one in Q1.45 and
  // half an output LSB in Q1.45.
  localparam longint UNITY_Q30 = 64'sd1 <<< 30;
  localparam longint UNITY_Q45 = 64'sd1 <<< 45;
  localparam longint HALF_LSB  = 64'sd1 <<< 29;

  // Every input is known from time zero.
  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [PROB_W-1:0] probability  = '0;
  logic              series_start = 1'b0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [PROB_W-1:0] refractory_probability;
  logic              saturated;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index    = '0;
  logic [DATA_W-1:0] cfg_data     = '0;

  typedef struct {
    logic [PROB_W-1:0] value;
    logic              clamped;
  } filter_output_t;

  // Local copy of the block's registers and history, kept in step with the
  // beats that were actually accepted.
  logic [TIU_W-1:0]  window_setting;
  logic [PROB_W-1:0] lag_weight [WEIGHT_REGS];
  logic [PROB_W-1:0] past_output [TAPS];

  filter_output_t predicted_outputs [$];

  int mismatch_count   = 0;
  int samples_sent     = 0;
  int send_idle_pct    = 0;
  int recv_idle_pct    = 0;
  int hold_off_left    = 0;

  refractory_probability_filter_core #(
    .TAPS(TAPS)
  ) DUT (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .probability            (probability),
    .series_start           (series_start),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .refractory_probability (refractory_probability),
    .saturated              (saturated),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #5 clk = ~clk;

  // The hold-off counter runs on its own; the test only loads it while it is
  // zero, so the two never assign it in the same step.
  always @(posedge clk) begin
    if (hold_off_left > 0) hold_off_left <= hold_off_left - 1;
  end

  // The receiver refuses beats for the whole hold-off and otherwise idles at
  // the rate of the current phase.
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Applies one register write to the local copy, with the same masking as
  // the block: three bits for the window, sixteen for a weight, nothing for
  // an index past the last weight.
  function automatic void note_register_write(input logic [IDX_W-1:0] idx,
                                              input logic [DATA_W-1:0] data);
    case (idx)
      REG_TAPS_IN_USE: window_setting = data[TIU_W-1:0];
      REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3,
      REG_WEIGHT_4, REG_WEIGHT_5, REG_WEIGHT_6: begin
        lag_weight[idx - REG_WEIGHT_1] = data;
      end
      default: ;
    endcase
  endfunction

  // Works out the output of one accepted beat and pushes it into the
  // history. The weighted sum is exact in Q2.30; the scaled value is exact
  // in Q1.45 and may go negative when the weights sum above one.
  function automatic filter_output_t predict_refractory(
      input logic [PROB_W-1:0] prob, input logic start);
    filter_output_t result;
    longint         weighted_sum;
    longint         scaled;
    longint         rounded;
    int             window;
    int             k;
    if (start) begin
      for (k = 0; k < TAPS; k++) past_output[k] = '0;
    end
    window = (window_setting > TAPS) ? TAPS : window_setting;
    weighted_sum = 0;
    for (k = 0; k < window; k++) begin
      // Lags past the last weight register carry no weight.
      if (k < WEIGHT_REGS) begin
        weighted_sum += longint'(lag_weight[k]) * longint'(past_output[k]);
      end
    end
    scaled = longint'(prob) * (UNITY_Q30 - weighted_sum);
    if (scaled < 0) begin
      result.value   = '0;
      result.clamped = 1'b1;
    end else if (scaled > UNITY_Q45) begin
      result.value   = ONE_Q15;
      result.clamped = 1'b1;
    end else begin
      rounded = (scaled + HALF_LSB) >>> 30;
      if (rounded > longint'(ONE_Q15)) rounded = longint'(ONE_Q15);
      result.value   = PROB_W'(rounded);
      result.clamped = 1'b0;
    end
    for (k = TAPS - 1; k > 0; k--) past_output[k] = past_output[k - 1];
    past_output[0] = result.value;
    return result;
  endfunction

  // Output checker: every beat the block hands over is matched against the
  // oldest prediction still waiting.
  always @(posedge clk) begin
    filter_output_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_outputs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected output beat at %0t: value %0d saturated %0b",
                   $time, refractory_probability, saturated);
        end
      end else begin
        want = predicted_outputs.pop_front();
        if (refractory_probability !== want.value || saturated !== want.clamped) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("output mismatch at %0t: expected value %0d saturated %0b, got value %0d saturated %0b",
                     $time, want.value, want.clamped, refractory_probability, saturated);
          end
        end
      end
    end
  end

  // Offers one probability beat, with a random gap in front of it at the
  // sender's idle rate. Valid stays high after acceptance so that back-to-back
  // beats never drop it for a cycle; whoever stops sending lowers it.
  task automatic send_sample(input logic [PROB_W-1:0] prob, input logic start);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    probability  <= prob;
    series_start <= start;
    do @(posedge clk); while (!in_ready);
    predicted_outputs.push_back(predict_refractory(prob, start));
    samples_sent++;
  endtask

  // Waits until every predicted output has been taken, then gives the block
  // a full beat time to settle before any register changes.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (TAPS + 3) @(posedge clk);
  endtask

  // Writes the window and the weights whose mask bit is set, and optionally
  // one write to the unused index. Bit 0 of the mask is the window, bit k the
  // weight of lag k. The block is drained first.
  task automatic apply_settings(input logic [TIU_W-1:0] taps,
                                input logic [5:0][PROB_W-1:0] weights,
                                input logic [6:0] write_mask,
                                input bit stray_write);
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    int                k;
    wait_until_idle();
    for (k = 0; k <= WEIGHT_REGS + 1; k++) begin
      if (k <= WEIGHT_REGS && write_mask[k]) begin
        idx  = IDX_W'(k);
        data = (k == 0) ? DATA_W'(taps) : weights[k - 1];
      end else if (k == WEIGHT_REGS + 1 && stray_write) begin
        idx  = REG_INDEX_UNUSED;
        data = DATA_W'($urandom_range(65535));
      end else begin
        continue;
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      do @(posedge clk); while (!cfg_ready);
      note_register_write(idx, data);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly probabilities in zero..one, with the two ends and the odd value
  // above one so that the upper clamp gets exercised.
  function automatic logic [PROB_W-1:0] pick_probability();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return ONE_Q15;
    if (roll < 20) return PROB_W'($urandom_range(65535));
    return PROB_W'($urandom_range(32768));
  endfunction

  // Weights span realistic small values, exactly one, and values past one.
  function automatic logic [PROB_W-1:0] pick_weight();
    case ($urandom_range(5))
      0:       return '0;
      1:       return ONE_Q15;
      2:       return 16'hFFFF;
      3:       return PROB_W'($urandom_range(65535));
      default: return PROB_W'($urandom_range(12000));
    endcase
  endfunction

  // One series: a start beat and then length-1 beats of history build-up.
  // Now and then a stray start lands in the middle of a series.
  task automatic send_series(input int length);
    int n;
    for (n = 0; n < length; n++) begin
      send_sample(pick_probability(), (n == 0) || ($urandom_range(99) < 3));
    end
  endtask

  // After reset every register is zero, so the window is empty and each
  // probability passes unchanged apart from the clamp above one.
  task automatic test_reset_defaults();
    send_sample(16'd0, 1'b1);
    send_sample(ONE_Q15, 1'b0);
    send_sample(16'd32769, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'd16384, 1'b0);
  endtask

  // A single lag: with weight one a full output cancels the next sample
  // exactly, with a weight above one it drives the result negative, and with
  // weight one half the rounding of small values shows.
  task automatic test_single_lag();
    logic [5:0][PROB_W-1:0] weights;
    weights    = '0;
    weights[0] = ONE_Q15;
    apply_settings(3'd1, weights, 7'b1111111, 1'b0);
    send_sample(ONE_Q15, 1'b1);
    send_sample(ONE_Q15, 1'b0);
    send_sample(16'd20000, 1'b0);
    send_sample(ONE_Q15, 1'b1);
    weights[0] = 16'hFFFF;
    apply_settings(3'd1, weights, 7'b0000010, 1'b0);
    send_sample(ONE_Q15, 1'b1);
    send_sample(ONE_Q15, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    weights[0] = 16'd16384;
    apply_settings(3'd1, weights, 7'b0000010, 1'b0);
    send_sample(16'd1, 1'b1);
    send_sample(16'd3, 1'b0);
    send_sample(16'd32767, 1'b0);
  endtask

  // Window value seven must behave as six. The write to the unused index
  // must leave every register alone.
  task automatic test_full_window();
    logic [5:0][PROB_W-1:0] weights;
    int                     k;
    for (k = 0; k < WEIGHT_REGS; k++) weights[k] = PROB_W'(32768 >> k);
    apply_settings(3'd7, weights, 7'b1111111, 1'b1);
    send_sample(ONE_Q15, 1'b1);
    for (k = 0; k < 7; k++) send_sample(16'd30000, 1'b0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering beats, so the block fills up and has to stall its input.
  task automatic test_output_hold_off();
    logic [5:0][PROB_W-1:0] weights;
    int                     k;
    for (k = 0; k < WEIGHT_REGS; k++) weights[k] = PROB_W'($urandom_range(8000));
    apply_settings(3'd6, weights, 7'b1111111, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left <= 300;
    send_series(20);
    send_series(20);
  endtask

  // Random series under random settings, in three idling phases: sender
  // idle 29 and receiver 66, then the reverse, then no idling at all.
  task automatic test_random_streams();
    logic [5:0][PROB_W-1:0] weights;
    int                     phase;
    int                     phase_target;
    int                     k;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 29; recv_idle_pct = 66; end
        1:       begin send_idle_pct = 66; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      phase_target = samples_sent + 620;
      while (samples_sent < phase_target) begin
        for (k = 0; k < WEIGHT_REGS; k++) weights[k] = pick_weight();
        apply_settings(TIU_W'($urandom_range(7)), weights,
                       7'($urandom_range(127)) | 7'b0000001,
                       ($urandom_range(9) == 0));
        repeat ($urandom_range(6, 3)) send_series($urandom_range(24, 1));
      end
    end
  endtask

  initial begin
    window_setting = '0;
    for (int k = 0; k < WEIGHT_REGS; k++) lag_weight[k] = '0;
    for (int k = 0; k < TAPS; k++) past_output[k] = '0;
    send_idle_pct = 29;
    recv_idle_pct = 66;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_single_lag();
    test_full_window();
    test_output_hold_off();
    test_random_streams();

    // Drain: every prediction must be matched, then a few beat times of
    // quiet catch any output beat that should not be there.
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (3 * (TAPS + 3)) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("testbench failed");
    $finish;
  end

endmodule
